### rtl/svm_pkg.sv
`timescale 1ns / 1ps
// svm_pkg: types, constants and register codes shared by the servo mixer.
// No dependencies; imported by every other file in rtl/.
package svm_pkg;

    localparam int AxisW    = 7;
    localparam int NeutW    = 6;
    localparam int FlapW    = 6;
    localparam int TrimW    = 10;
    localparam int PulseW   = 12;
    localparam int NumNeut  = 5;
    localparam int CfgAddrW = 3;
    localparam int CalcW    = 14;   // signed working width for the mix sums

    localparam int PulseBase  = 1000;
    localparam int NoseBase   = 1300;
    localparam int ThrBase    = 1050;
    localparam int ThrScale   = 9;
    localparam int AxisScale  = 10;
    localparam int NoseScale  = 4;
    localparam int NoseCentre = 100;
    localparam int FlapStep   = 13;
    localparam int FlapMax    = 39;
    localparam int TrimLimit  = 400;

    // |trim| / 10 as (|trim| * 205) >> 11, exact for |trim| below 1029
    localparam int TrimMagW    = TrimW - 1;
    localparam int Recip10     = 205;
    localparam int Recip10W    = 8;
    localparam int Recip10Shft = 11;
    localparam int TrimQuotW   = 6;

    typedef logic signed [NeutW-1:0] svm_neut_t;
    typedef svm_neut_t [NumNeut-1:0] svm_neut_arr_t;

    typedef enum logic [CfgAddrW-1:0] {
        REG_LEFT_AIL  = 3'd0,
        REG_RIGHT_AIL = 3'd1,
        REG_ELEVATOR  = 3'd2,
        REG_RUDDER    = 3'd3,
        REG_NOSE      = 3'd4
    } svm_reg_idx_t;

    localparam svm_neut_t NeutResetLeft  = -6'sd5;
    localparam svm_neut_t NeutResetRight = -6'sd3;
    localparam svm_neut_t NeutResetElev  = -6'sd6;
    localparam svm_neut_t NeutResetRud   = -6'sd2;
    localparam svm_neut_t NeutResetNose  = -6'sd27;

    // Input word, roll_axis in the lowest bits
    typedef struct packed {
        logic             flap_raise;
        logic             flap_lower;
        logic             trim_down;
        logic             trim_up;
        logic             trim_clear;
        logic             arm_switch;
        logic [AxisW-1:0] throttle_axis;
        logic [AxisW-1:0] yaw_axis;
        logic [AxisW-1:0] pitch_axis;
        logic [AxisW-1:0] roll_axis;
    } svm_item_t;

    localparam int ItemW  = $bits(svm_item_t);
    localparam int SDataW = ((ItemW + 7) / 8) * 8;

    // Result word, left_aileron_pulse in the lowest bits
    typedef struct packed {
        logic [PulseW-1:0] throttle_pulse;
        logic [PulseW-1:0] nose_wheel_pulse;
        logic [PulseW-1:0] rudder_pulse;
        logic [PulseW-1:0] elevator_pulse;
        logic [PulseW-1:0] right_aileron_pulse;
        logic [PulseW-1:0] left_aileron_pulse;
    } svm_result_t;

    localparam int MDataW = $bits(svm_result_t);

    // Tick state as seen before the current word, plus the new arming decision
    typedef struct packed {
        logic                    armed;
        logic                    arm_next;
        logic [FlapW-1:0]        flap_offset;
        logic signed [TrimW-1:0] pitch_trim;
    } svm_ctrl_t;

endpackage

### rtl/svm_state.sv
`timescale 1ns / 1ps
// svm_state: arming, flaperon and elevator trim state, advanced once per word.
// Depends on svm_pkg.
module svm_state
    import svm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      advance,
    input  svm_item_t item,
    output svm_ctrl_t ctrl
);

    logic                    armed_reg;
    logic [FlapW-1:0]        flap_reg, flap_next, flap_mid;
    logic                    last_lower_reg, last_raise_reg;
    logic signed [TrimW-1:0] trim_reg, trim_next, trim_mid;
    logic                    arm_next;

    assign arm_next = item.arm_switch && (armed_reg || (item.throttle_axis == '0));

    always_comb begin
        flap_mid = flap_reg;
        if (item.flap_lower && !last_lower_reg && (flap_reg < FlapW'(FlapMax))) begin
            flap_mid = flap_reg + FlapW'(FlapStep);
        end
        flap_next = flap_mid;
        if (item.flap_raise && !last_raise_reg && (flap_mid != '0)) begin
            flap_next = flap_mid - FlapW'(FlapStep);
        end
    end

    always_comb begin
        trim_mid = trim_reg;
        if (item.trim_up && (trim_reg < TrimW'(TrimLimit))) begin
            trim_mid = trim_reg + TrimW'(1);
        end
        trim_next = trim_mid;
        if (item.trim_down && (trim_mid > -TrimW'(TrimLimit))) begin
            trim_next = trim_mid - TrimW'(1);
        end
        if (item.trim_clear) begin
            trim_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg      <= 1'b0;
            flap_reg       <= '0;
            last_lower_reg <= 1'b0;
            last_raise_reg <= 1'b0;
            trim_reg       <= '0;
        end else if (advance) begin
            armed_reg      <= arm_next;
            flap_reg       <= flap_next;
            last_lower_reg <= item.flap_lower;
            last_raise_reg <= item.flap_raise;
            trim_reg       <= trim_next;
        end
    end

    assign ctrl.armed       = armed_reg;
    assign ctrl.arm_next    = arm_next;
    assign ctrl.flap_offset = flap_reg;
    assign ctrl.pitch_trim  = trim_reg;

endmodule

### rtl/svm_mixer.sv
`timescale 1ns / 1ps
// svm_mixer: combinational servo mix from one input word and the tick state.
// Depends on svm_pkg.
module svm_mixer
    import svm_pkg::*;
(
    input  svm_item_t     item,
    input  svm_ctrl_t     ctrl,
    input  svm_neut_arr_t neutral,
    output svm_result_t   result
);

    localparam logic signed [CalcW-1:0] CPulse = CalcW'(PulseBase);
    localparam logic signed [CalcW-1:0] CNose  = CalcW'(NoseBase);
    localparam logic signed [CalcW-1:0] CCentre = CalcW'(NoseCentre);
    localparam logic signed [CalcW-1:0] CAxis  = CalcW'(AxisScale);
    localparam logic signed [CalcW-1:0] CNoseK = CalcW'(NoseScale);

    logic signed [CalcW-1:0] roll_s, pitch_s, yaw_s, flap_s;
    logic signed [CalcW-1:0] n_la, n_ra, n_el, n_ru, n_nw;
    logic [TrimMagW-1:0]     trim_mag;
    logic [TrimW-1:0]        trim_neg;
    logic [TrimMagW+Recip10W-1:0] trim_prod;
    logic [TrimQuotW-1:0]    quot_mag;
    logic signed [CalcW-1:0] quot_s;
    logic signed [CalcW-1:0] la, ra, el, ru, nw;
    logic [PulseW-1:0]       thr_live;

    assign roll_s  = $signed({{(CalcW-AxisW){1'b0}}, item.roll_axis});
    assign pitch_s = $signed({{(CalcW-AxisW){1'b0}}, item.pitch_axis});
    assign yaw_s   = $signed({{(CalcW-AxisW){1'b0}}, item.yaw_axis});
    assign flap_s  = $signed({{(CalcW-FlapW){1'b0}}, ctrl.flap_offset});

    assign n_la = $signed({{(CalcW-NeutW){neutral[REG_LEFT_AIL][NeutW-1]}},
                           neutral[REG_LEFT_AIL]});
    assign n_ra = $signed({{(CalcW-NeutW){neutral[REG_RIGHT_AIL][NeutW-1]}},
                           neutral[REG_RIGHT_AIL]});
    assign n_el = $signed({{(CalcW-NeutW){neutral[REG_ELEVATOR][NeutW-1]}},
                           neutral[REG_ELEVATOR]});
    assign n_ru = $signed({{(CalcW-NeutW){neutral[REG_RUDDER][NeutW-1]}},
                           neutral[REG_RUDDER]});
    assign n_nw = $signed({{(CalcW-NeutW){neutral[REG_NOSE][NeutW-1]}},
                           neutral[REG_NOSE]});

    // trim / 10 truncated toward zero: divide the magnitude, restore the sign
    assign trim_neg  = -ctrl.pitch_trim;
    assign trim_mag  = ctrl.pitch_trim[TrimW-1] ? trim_neg[TrimMagW-1:0]
                                                : ctrl.pitch_trim[TrimMagW-1:0];
    assign trim_prod = trim_mag * Recip10W'(Recip10);
    assign quot_mag  = trim_prod[Recip10Shft +: TrimQuotW];
    assign quot_s    = ctrl.pitch_trim[TrimW-1]
                     ? -$signed({{(CalcW-TrimQuotW){1'b0}}, quot_mag})
                     :  $signed({{(CalcW-TrimQuotW){1'b0}}, quot_mag});

    assign la = CPulse + CAxis * (roll_s + n_la + flap_s);
    assign ra = CPulse + CAxis * (roll_s + n_ra - flap_s);
    assign el = CPulse + CAxis * (pitch_s + n_el - quot_s);
    assign ru = CPulse + CAxis * (yaw_s + n_ru);
    assign nw = CNose + CNoseK * (CCentre - yaw_s + n_nw);

    assign thr_live = PulseW'(ThrBase)
                    + PulseW'(item.throttle_axis) * PulseW'(ThrScale);

    assign result.left_aileron_pulse  = la[PulseW-1:0];
    assign result.right_aileron_pulse = ra[PulseW-1:0];
    assign result.elevator_pulse      = el[PulseW-1:0];
    assign result.rudder_pulse        = ru[PulseW-1:0];
    assign result.nose_wheel_pulse    = nw[PulseW-1:0];
    assign result.throttle_pulse      = (ctrl.armed && ctrl.arm_next)
                                      ? thr_live : PulseW'(PulseBase);

endmodule

### rtl/servo_mixer_with_trim_and_arming.sv
`timescale 1ns / 1ps
// servo_mixer_with_trim_and_arming: an input word reaches the result word through
// the input register, then the result register; throughput one word per cycle while
// m_tready does not stall the result register, with a single mix pass between them.
// aresetn (synchronous, active low) empties both stages, disarms the throttle,
// zeroes flaperon offset and trim, and loads the default neutral trims.
// Depends on svm_pkg, svm_state, svm_mixer.
module servo_mixer_with_trim_and_arming
    import svm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    // Input stream
    input  logic                s_tvalid,
    output logic                s_tready,
    // s_tdata, low bit up: roll_axis[6:0], pitch_axis[13:7], yaw_axis[20:14],
    // throttle_axis[27:21], arm_switch[28], trim_clear[29], trim_up[30],
    // trim_down[31], flap_lower[32], flap_raise[33], zero pad [39:34]
    input  logic [SDataW-1:0]   s_tdata,

    // Result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    // m_tdata, low bit up, 12 bits each: left_aileron_pulse,
    // right_aileron_pulse, elevator_pulse, rudder_pulse, nose_wheel_pulse,
    // throttle_pulse
    output logic [MDataW-1:0]   m_tdata,

    // Neutral trim registers, written only while idle: user's rule, not enforced
    input  logic                cfg_wr_en,
    input  logic [CfgAddrW-1:0] cfg_addr,
    input  logic [NeutW-1:0]    cfg_wdata
);

    logic          in_valid_reg;
    svm_item_t     in_item_reg;
    logic          out_valid_reg;
    svm_result_t   out_data_reg;
    logic          out_free;
    logic          advance;
    svm_neut_arr_t neutral_reg;
    svm_ctrl_t     ctrl;
    svm_result_t   result;

    // The result register frees up when empty or being drained; the input register
    // moves on in the same cycle, so a word can enter each cycle without a stall.
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg <= s_tdata[ItemW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= result;
        end
    end

    // Neutral trims; indices past the nose wheel are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            neutral_reg[REG_LEFT_AIL]  <= NeutResetLeft;
            neutral_reg[REG_RIGHT_AIL] <= NeutResetRight;
            neutral_reg[REG_ELEVATOR]  <= NeutResetElev;
            neutral_reg[REG_RUDDER]    <= NeutResetRud;
            neutral_reg[REG_NOSE]      <= NeutResetNose;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_LEFT_AIL:  neutral_reg[REG_LEFT_AIL]  <= cfg_wdata;
                REG_RIGHT_AIL: neutral_reg[REG_RIGHT_AIL] <= cfg_wdata;
                REG_ELEVATOR:  neutral_reg[REG_ELEVATOR]  <= cfg_wdata;
                REG_RUDDER:    neutral_reg[REG_RUDDER]    <= cfg_wdata;
                REG_NOSE:      neutral_reg[REG_NOSE]      <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Tick state moves only when a word passes into the result register, so
    // the mix always sees the state left by the previous word.
    svm_state u_state (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_item_reg),
        .ctrl    (ctrl)
    );

    svm_mixer u_mixer (
        .item    (in_item_reg),
        .ctrl    (ctrl),
        .neutral (neutral_reg),
        .result  (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

### test/servo_pulse_checker.sv
`timescale 1ns / 1ps
// servo_pulse_checker: watches both streams and the neutral write port of the
// servo mixer, predicts every pulse word and compares it field by field.
// Depends on svm_pkg only.
module servo_pulse_checker
    import svm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    // s_tdata, low bit up: roll, pitch, yaw, throttle, arm, clear, up, down,
    // flap_lower, flap_raise, zero pad
    input  logic [SDataW-1:0]   s_tdata,
    input  logic                m_tvalid,
    input  logic                m_tready,
    // m_tdata, low bit up: left aileron, right aileron, elevator, rudder,
    // nose wheel, throttle pulses
    input  logic [MDataW-1:0]   m_tdata,
    input  logic                cfg_wr_en,
    input  logic [CfgAddrW-1:0] cfg_addr,
    input  logic [NeutW-1:0]    cfg_wdata,
    output int                  mismatch_count,
    output int                  pulses_owed
);

    localparam int PrintCap = 60;

    // predictor state, mirrors the block's own
    int                      neutral [NumNeut];
    logic                    armed;
    logic [FlapW-1:0]        flap_offset;
    logic                    last_lower;
    logic                    last_raise;
    logic signed [TrimW-1:0] pitch_trim;

    svm_result_t expected_pulses [$];

    initial mismatch_count = 0;
    initial pulses_owed = 0;

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PrintCap)
            $display("%0t ns  servo pulse: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [PulseW-1:0] got,
                               input logic [PulseW-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    // One control tick: pulses from the state before the word, then the
    // buttons move the state on.
    function automatic svm_result_t mix_tick(input svm_item_t w);
        svm_result_t r;
        int   roll, pitch, yaw, thr, flap, trim_q;
        logic arm_next;
        roll   = int'(w.roll_axis);
        pitch  = int'(w.pitch_axis);
        yaw    = int'(w.yaw_axis);
        thr    = int'(w.throttle_axis);
        flap   = int'(flap_offset);
        trim_q = int'(pitch_trim) / 10;     // truncates toward zero

        r.left_aileron_pulse  = PulseW'(PulseBase
                                + AxisScale * (roll + neutral[REG_LEFT_AIL] + flap));
        r.right_aileron_pulse = PulseW'(PulseBase
                                + AxisScale * (roll + neutral[REG_RIGHT_AIL] - flap));
        r.elevator_pulse      = PulseW'(PulseBase
                                + AxisScale * (pitch + neutral[REG_ELEVATOR] - trim_q));
        r.rudder_pulse        = PulseW'(PulseBase
                                + AxisScale * (yaw + neutral[REG_RUDDER]));
        r.nose_wheel_pulse    = PulseW'(NoseBase
                                + NoseScale * (NoseCentre - yaw + neutral[REG_NOSE]));

        arm_next = w.arm_switch && (armed || thr == 0);
        r.throttle_pulse = (armed && arm_next) ? PulseW'(ThrBase + ThrScale * thr)
                                               : PulseW'(PulseBase);
        armed = arm_next;

        if (w.flap_lower && !last_lower && flap_offset < FlapMax)
            flap_offset = flap_offset + FlapW'(FlapStep);
        if (w.flap_raise && !last_raise && flap_offset > 0)
            flap_offset = flap_offset - FlapW'(FlapStep);
        last_lower = w.flap_lower;
        last_raise = w.flap_raise;

        if (w.trim_up && pitch_trim < TrimLimit)
            pitch_trim = pitch_trim + 1;
        if (w.trim_down && pitch_trim > -TrimLimit)
            pitch_trim = pitch_trim - 1;
        if (w.trim_clear)
            pitch_trim = '0;
        return r;
    endfunction

    always @(posedge aclk) begin
        svm_result_t got, want;
        if (!aresetn) begin
            neutral[REG_LEFT_AIL]  = int'(NeutResetLeft);
            neutral[REG_RIGHT_AIL] = int'(NeutResetRight);
            neutral[REG_ELEVATOR]  = int'(NeutResetElev);
            neutral[REG_RUDDER]    = int'(NeutResetRud);
            neutral[REG_NOSE]      = int'(NeutResetNose);
            armed       = 1'b0;
            flap_offset = '0;
            last_lower  = 1'b0;
            last_raise  = 1'b0;
            pitch_trim  = '0;
            expected_pulses.delete();
        end else begin
            if (cfg_wr_en && cfg_addr < NumNeut)
                neutral[cfg_addr] = int'($signed(cfg_wdata));
            // retire first so a word that nothing asked for is caught
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_pulses.size() == 0) begin
                    report_mismatch($sformatf("result word %h with none owed", m_tdata));
                end else begin
                    want = expected_pulses.pop_front();
                    check_field("left aileron",  got.left_aileron_pulse,
                                want.left_aileron_pulse);
                    check_field("right aileron", got.right_aileron_pulse,
                                want.right_aileron_pulse);
                    check_field("elevator",      got.elevator_pulse, want.elevator_pulse);
                    check_field("rudder",        got.rudder_pulse, want.rudder_pulse);
                    check_field("nose wheel",    got.nose_wheel_pulse,
                                want.nose_wheel_pulse);
                    check_field("throttle",      got.throttle_pulse, want.throttle_pulse);
                end
            end
            if (s_tvalid && s_tready)
                expected_pulses.push_back(mix_tick(s_tdata[ItemW-1:0]));
        end
        pulses_owed <= expected_pulses.size();
    end

endmodule

### test/tb_servo_mixer_with_trim_and_arming.sv
`timescale 1ns / 1ps
// tb_servo_mixer_with_trim_and_arming: drives stick words and neutral writes
// into the servo mixer and gives the verdict; checking is in servo_pulse_checker.
// Depends on svm_pkg, servo_pulse_checker and the mixer RTL.
module tb_servo_mixer_with_trim_and_arming;
    import svm_pkg::*;

    localparam int ResetCycles   = 11;
    localparam int Latency       = 2;      // input reg then result reg
    localparam int HoldOffCycles = 300;    // long receiver stall for back-pressure
    localparam int WatchdogLimit = 3000;   // idle cycles before giving up
    localparam int RandomTicks   = 15;     // per random chunk, four chunks-ish

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [SDataW-1:0]   s_tdata;     // roll, pitch, yaw, throttle, buttons, pad
    logic                m_tvalid;
    logic                m_tready;
    logic [MDataW-1:0]   m_tdata;     // six 12-bit pulses, left aileron lowest
    logic                cfg_wr_en;
    logic [CfgAddrW-1:0] cfg_addr;
    logic [NeutW-1:0]    cfg_wdata;

    int   mismatch_count;
    int   pulses_owed;

    // sender bookkeeping
    int   ticks_sent  = 0;
    int   burst_left  = 0;
    logic steady      = 1'b0;   // no gaps while set
    logic hold_off_req;         // written by the stimulus only
    logic hold_off_done;        // written by the receiver only
    int   idle_cycles = 0;

    always #4 aclk = ~aclk;

    servo_mixer_with_trim_and_arming dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    servo_pulse_checker u_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .pulses_owed    (pulses_owed)
    );

    // ---------------------------------------------------------------------
    // Watchdog: any accepted word on either side resets the idle count.
    // ---------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WatchdogLimit) begin
            $display("servo_mixer_with_trim_and_arming: mismatch");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Receiver: cycles through its own stall patterns; on request it holds
    // off for a long stretch so the block fills and stalls its input.
    // ---------------------------------------------------------------------
    initial begin
        int cyc;
        int mode;
        cyc = 0;
        m_tready      <= 1'b0;
        hold_off_done <= 1'b0;
        forever begin
            @(posedge aclk);
            cyc++;
            if (hold_off_req && !hold_off_done) begin
                m_tready <= 1'b0;
                repeat (HoldOffCycles) @(posedge aclk);
                hold_off_done <= 1'b1;
            end else begin
                mode = (cyc / 97) % 4;
                case (mode)
                    0: m_tready <= 1'b1;                          // free running
                    1: m_tready <= 1'($urandom_range(1, 0));      // coin toss
                    2: m_tready <= ($urandom_range(3, 0) != 0);   // light stalls
                    default: m_tready <= (cyc % 5 == 0);          // slow sink
                endcase
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------

    // axis value biased towards both ends of travel
    function automatic logic [AxisW-1:0] rand_axis();
        case ($urandom_range(7, 0))
            0:       return '0;
            1:       return '1;
            default: return AxisW'($urandom_range((1 << AxisW) - 1, 0));
        endcase
    endfunction

    function automatic svm_item_t stick_word(input int roll, pitch, yaw, thr,
                                             input logic arm, clr, up, dn, lo, ra);
        svm_item_t w;
        w.roll_axis     = AxisW'(roll);
        w.pitch_axis    = AxisW'(pitch);
        w.yaw_axis      = AxisW'(yaw);
        w.throttle_axis = AxisW'(thr);
        w.arm_switch    = arm;
        w.trim_clear    = clr;
        w.trim_up       = up;
        w.trim_down     = dn;
        w.flap_lower    = lo;
        w.flap_raise    = ra;
        return w;
    endfunction

    // Present one word and wait for the handshake; bursts of random length
    // are broken by random gaps unless steady is set.
    task automatic offer(input svm_item_t w);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= SDataW'(w);
        do @(posedge aclk); while (!s_tready);
        ticks_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(40, 1);
            if (!steady) begin
                gap = $urandom_range(12, 1);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Stop sending and wait until every owed pulse word is back, then let
    // the pipeline settle.  pulses_owed is a registered copy, hence the first wait.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pulses_owed != 0) @(posedge aclk);
        repeat (Latency) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [NeutW-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    // All five neutrals, then junk into the unused indexes (must be ignored)
    task automatic load_neutrals(input svm_neut_t l, r, e, ru, n);
        write_reg(REG_LEFT_AIL,  l);
        write_reg(REG_RIGHT_AIL, r);
        write_reg(REG_ELEVATOR,  e);
        write_reg(REG_RUDDER,    ru);
        write_reg(REG_NOSE,      n);
        for (int a = NumNeut; a < (1 << CfgAddrW); a++)
            write_reg(CfgAddrW'(a), NeutW'($urandom()));
        cfg_wr_en <= 1'b0;
    endtask

    // Random flying: mostly well-formed sequences (arm then fly, flap
    // clicks, trim runs) with random content, some noise in between.
    task automatic random_flight(input int n_ticks);
        int        goal, kind, len;
        logic      trim_dir;
        svm_item_t w;
        goal = ticks_sent + n_ticks;
        while (ticks_sent < goal) begin
            kind     = $urandom_range(9, 0);
            len      = $urandom_range(24, 3);
            trim_dir = 1'($urandom_range(1, 0));
            for (int k = 0; k < len; k++) begin
                w = ItemW'({$urandom(), $urandom()});
                w.roll_axis     = rand_axis();
                w.pitch_axis    = rand_axis();
                w.yaw_axis      = rand_axis();
                w.throttle_axis = rand_axis();
                case (kind)
                    2, 3, 4: begin
                        // hat held from idle, now and then released mid-flight
                        w.arm_switch = (k == 0) || ($urandom_range(11, 0) != 0);
                        if (k == 0)
                            w.throttle_axis = '0;
                        w.trim_clear = 1'b0;
                    end
                    5, 6: begin
                        // flap clicking, trim left alone
                        w.trim_up    = 1'b0;
                        w.trim_down  = 1'b0;
                        w.trim_clear = 1'b0;
                    end
                    7, 8: begin
                        w.trim_up    = trim_dir || ($urandom_range(7, 0) == 0);
                        w.trim_down  = !trim_dir || ($urandom_range(7, 0) == 0);
                        w.trim_clear = ($urandom_range(15, 0) == 0);
                    end
                    default: ;  // noise
                endcase
                offer(w);
            end
        end
    endtask

    // Drive trim from zero all the way into one limit, then press both
    // buttons at the limit where they no longer cancel.
    task automatic trim_to_limit(input logic raise);
        svm_item_t w;
        for (int k = 0; k < TrimLimit + 12; k++) begin
            w = ItemW'({$urandom(), $urandom()});
            w.roll_axis  = rand_axis();
            w.pitch_axis = rand_axis();
            w.trim_clear = (k == 0);
            w.trim_up    = raise || (k >= TrimLimit + 6);
            w.trim_down  = !raise || (k >= TrimLimit + 6);
            offer(w);
        end
    endtask

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin
        aresetn      <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        cfg_wr_en    <= 1'b0;
        cfg_addr     <= '0;
        cfg_wdata    <= '0;
        hold_off_req <= 1'b0;
        repeat (ResetCycles) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed, default neutrals
        //               roll pit yaw thr arm clr up dn lo ra
        offer(stick_word(  0,   0,  0,  0, 0, 0, 0, 0, 0, 0));
        offer(stick_word(127, 127,127,127, 0, 0, 0, 0, 0, 0));
        offer(stick_word( 64,  64, 64,  5, 1, 0, 0, 0, 0, 0)); // hat with throttle open
        offer(stick_word( 64,  64, 64,  0, 1, 0, 0, 0, 0, 0)); // arms
        offer(stick_word(127,   0,  0,127, 1, 0, 0, 0, 0, 0)); // full throttle
        offer(stick_word(  0, 127,127,  0, 1, 0, 0, 0, 0, 0)); // armed at idle
        offer(stick_word( 64,  64, 64, 64, 0, 0, 0, 0, 0, 0)); // hat released
        offer(stick_word( 64,  64, 64, 64, 1, 0, 0, 0, 0, 0)); // no re-arm off idle
        offer(stick_word(100,  27,  3,  0, 0, 0, 0, 0, 1, 0)); // flap down click
        offer(stick_word(100,  27,  3,  0, 0, 0, 0, 0, 1, 0)); // held: no step
        offer(stick_word(100,  27,  3,  0, 0, 0, 0, 0, 0, 0));
        offer(stick_word( 12,  90, 50,  0, 0, 0, 0, 0, 1, 0));
        offer(stick_word( 12,  90, 50,  0, 0, 0, 0, 0, 0, 0));
        offer(stick_word( 12,  90, 50,  0, 0, 0, 0, 0, 1, 0)); // reaches the top
        offer(stick_word( 12,  90, 50,  0, 0, 0, 0, 0, 0, 0));
        offer(stick_word( 12,  90, 50,  0, 0, 0, 0, 0, 1, 0)); // click at the top
        offer(stick_word( 80,  40, 70,  0, 0, 0, 0, 0, 0, 0));
        offer(stick_word( 80,  40, 70,  0, 0, 0, 0, 0, 1, 1)); // both, lower blocked
        offer(stick_word( 80,  40, 70,  0, 0, 0, 0, 0, 0, 0));
        offer(stick_word( 80,  40, 70,  0, 0, 0, 0, 0, 1, 1)); // both, net unchanged
        offer(stick_word( 33, 101, 20,  0, 0, 0, 1, 0, 0, 0)); // trim up
        offer(stick_word( 33, 101, 20,  0, 0, 0, 1, 1, 0, 0)); // up and down cancel
        offer(stick_word( 33, 101, 20,  0, 0, 0, 0, 1, 0, 0));
        offer(stick_word( 33, 101, 20,  0, 0, 0, 0, 1, 0, 0)); // trim goes negative
        offer(stick_word( 33, 101, 20,  0, 0, 1, 1, 0, 0, 0)); // clear beats up

        // most negative neutrals
        settle();
        load_neutrals(-6'sd32, -6'sd32, -6'sd32, -6'sd32, -6'sd32);
        random_flight(RandomTicks);

        // most positive neutrals, trim up into its limit
        settle();
        load_neutrals(6'sd31, 6'sd31, 6'sd31, 6'sd31, 6'sd31);
        trim_to_limit(1'b1);
        random_flight(RandomTicks);

        // random neutrals, then a long receiver hold-off with the sender
        // pushing back to back
        settle();
        load_neutrals(NeutW'($urandom()), NeutW'($urandom()), NeutW'($urandom()),
                      NeutW'($urandom()), NeutW'($urandom()));
        steady       = 1'b1;
        hold_off_req <= 1'b1;
        random_flight(30);
        while (!hold_off_done) @(posedge aclk);
        steady = 1'b0;
        random_flight(RandomTicks);

        // mixed extremes
        settle();
        load_neutrals(6'sd31, -6'sd32, 6'sd0, -6'sd1, 6'sd31);
        random_flight(RandomTicks);

        settle();
        if (mismatch_count == 0)
            $display("servo_mixer_with_trim_and_arming: match");
        else
            $display("servo_mixer_with_trim_and_arming: mismatch");
        $finish;
    end

endmodule

### sim.f
rtl/svm_pkg.sv
rtl/svm_state.sv
rtl/svm_mixer.sv
rtl/servo_mixer_with_trim_and_arming.sv
test/servo_pulse_checker.sv
test/tb_servo_mixer_with_trim_and_arming.sv
